### src/jsat_pkg.sv
// Package for the JSON string array tokenizer: item, token and burst types,
// character codes, and the byte-step and end-of-text functions of the parser.
// Used by every module in src.
package jsat_pkg;

  typedef enum logic [2:0] {
    PH_SEEK,
    PH_LIST,
    PH_STR,
    PH_ESC,
    PH_HEXD,
    PH_HEXR,
    PH_DONE
  } phase_t;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_EOS  = 2'd1;
  localparam logic [1:0] KIND_EOL  = 2'd2;

  localparam logic [7:0] WS_MAX    = 8'h20;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_R   = 8'h72;
  localparam logic [7:0] CH_LC_T   = 8'h74;
  localparam logic [7:0] CH_LC_U   = 8'h75;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;

  localparam logic [15:0] CP_ONE_LIMIT = 16'h0080;
  localparam logic [15:0] CP_TWO_LIMIT = 16'h0800;

  // Up to eight tokens can come out of one input byte.
  localparam int MAX_TOK    = 8;
  localparam int TOK_IDX_W  = $clog2(MAX_TOK);
  localparam int TOK_CNT_W  = TOK_IDX_W + 1;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [1:0] out_kind;
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
  } tok_t;

  typedef struct packed {
    tok_t [MAX_TOK-1:0]   tok;
    logic [TOK_CNT_W-1:0] cnt;
  } burst_t;

  typedef struct packed {
    phase_t          phase;
    logic [1:0]      hex_count;
    logic [15:0]     hex_value;
    logic [2:0][7:0] held;
  } pstate_t;

  typedef struct packed {
    pstate_t st;
    burst_t  acc;
  } step_t;

  // Record handed from the byte parser to the end-of-text stage.
  typedef struct packed {
    step_t step;
    logic  last;
  } rec_t;

  function automatic burst_t push_tok(burst_t acc, logic [1:0] kind, logic [7:0] b);
    burst_t r;
    r = acc;
    if (acc.cnt < TOK_CNT_W'(MAX_TOK)) begin
      r.tok[acc.cnt[TOK_IDX_W-1:0]].kind = kind;
      r.tok[acc.cnt[TOK_IDX_W-1:0]].data = (kind == KIND_DATA) ? b : 8'h00;
      r.cnt = acc.cnt + TOK_CNT_W'(1);
    end
    return r;
  endfunction

  // Bit 4 flags a hex digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_digit(logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, b[3:0]};
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      r = {1'b1, b[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic burst_t emit_utf8(burst_t acc, logic [15:0] cp);
    burst_t r;
    r = acc;
    if (cp < CP_ONE_LIMIT) begin
      r = push_tok(r, KIND_DATA, cp[7:0]);
    end else if (cp < CP_TWO_LIMIT) begin
      r = push_tok(r, KIND_DATA, {3'b110, cp[10:6]});
      r = push_tok(r, KIND_DATA, {2'b10, cp[5:0]});
    end else begin
      r = push_tok(r, KIND_DATA, {4'b1110, cp[15:12]});
      r = push_tok(r, KIND_DATA, {2'b10, cp[11:6]});
      r = push_tok(r, KIND_DATA, {2'b10, cp[5:0]});
    end
    return r;
  endfunction

  // One byte through the parser.
  function automatic step_t feed(step_t s, logic [7:0] b);
    step_t      r;
    logic [4:0] hd;
    r  = s;
    hd = hex_digit(b);
    unique case (s.st.phase)
      PH_SEEK: begin
        if (b > WS_MAX) r.st.phase = (b == CH_LBRACK) ? PH_LIST : PH_DONE;
      end
      PH_LIST: begin
        if (b == CH_RBRACK) begin
          r.acc      = push_tok(r.acc, KIND_EOL, 8'h00);
          r.st.phase = PH_DONE;
        end else if (b == CH_QUOTE) begin
          r.st.phase = PH_STR;
        end
      end
      PH_STR: begin
        if (b == CH_QUOTE) begin
          r.acc      = push_tok(r.acc, KIND_EOS, 8'h00);
          r.st.phase = PH_LIST;
        end else if (b == CH_BSLASH) begin
          r.st.phase = PH_ESC;
        end else begin
          r.acc = push_tok(r.acc, KIND_DATA, b);
        end
      end
      PH_ESC: begin
        r.st.phase = PH_STR;
        if (b == CH_LC_N) begin
          r.acc = push_tok(r.acc, KIND_DATA, CH_LF);
        end else if (b == CH_LC_R) begin
          r.acc = push_tok(r.acc, KIND_DATA, CH_CR);
        end else if (b == CH_LC_T) begin
          r.acc = push_tok(r.acc, KIND_DATA, CH_TAB);
        end else if (b == CH_LC_U) begin
          r.st.phase     = PH_HEXD;
          r.st.hex_count = 2'd0;
          r.st.hex_value = 16'h0000;
        end else begin
          r.acc = push_tok(r.acc, KIND_DATA, b);
        end
      end
      PH_HEXD, PH_HEXR: begin
        // Digits only count until the first non-hex byte.
        if (s.st.phase == PH_HEXD) begin
          if (hd[4]) r.st.hex_value = {s.st.hex_value[11:0], hd[3:0]};
          else r.st.phase = PH_HEXR;
        end
        if (s.st.hex_count != 2'd3) begin
          r.st.held[s.st.hex_count] = b;
          r.st.hex_count            = s.st.hex_count + 2'd1;
        end else begin
          r.acc          = emit_utf8(r.acc, r.st.hex_value);
          r.st.hex_count = 2'd0;
          r.st.hex_value = 16'h0000;
          r.st.phase     = PH_STR;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Close the text after its last byte.
  function automatic step_t finish(step_t s);
    step_t           r;
    logic [2:0][7:0] tmp;
    logic [1:0]      n;
    r = s;
    // Held bytes of an unfinished \u are read again as string text.
    if (r.st.phase == PH_HEXD || r.st.phase == PH_HEXR) begin
      tmp            = r.st.held;
      n              = r.st.hex_count;
      r.st.phase     = PH_STR;
      r.st.hex_count = 2'd0;
      r.st.hex_value = 16'h0000;
      if (n > 2'd0) r = feed(r, tmp[0]);
      if (n > 2'd1) r = feed(r, tmp[1]);
      if (n > 2'd2) r = feed(r, tmp[2]);
    end
    // A second \u can only open on the first two reparsed bytes, so it holds
    // at most one byte, and that byte cannot open a third.
    if (r.st.phase == PH_HEXD || r.st.phase == PH_HEXR) begin
      tmp            = r.st.held;
      n              = r.st.hex_count;
      r.st.phase     = PH_STR;
      r.st.hex_count = 2'd0;
      r.st.hex_value = 16'h0000;
      if (n != 2'd0) r = feed(r, tmp[0]);
    end
    if (r.st.phase == PH_ESC) begin
      r.acc      = push_tok(r.acc, KIND_DATA, CH_BSLASH);
      r.st.phase = PH_STR;
    end
    if (r.st.phase == PH_STR) begin
      r.acc      = push_tok(r.acc, KIND_EOS, 8'h00);
      r.st.phase = PH_LIST;
    end
    if (r.st.phase == PH_LIST) r.acc = push_tok(r.acc, KIND_EOL, 8'h00);
    r.st.phase     = PH_SEEK;
    r.st.hex_count = 2'd0;
    r.st.hex_value = 16'h0000;
    return r;
  endfunction

endpackage

### src/jsat_parse.sv
// Front end, first stage: takes one text byte per cycle while not stalled, steps the
// parser state and registers the tokens of that byte. Depends on jsat_pkg.
module jsat_parse import jsat_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     byte_valid,
  output logic     byte_stall,
  input  in_item_t byte_data,
  output logic     rec_valid,
  input  logic     rec_stall,
  output rec_t     rec
);

  pstate_t st;
  pstate_t st_next;
  step_t   cur;
  step_t   stepped;
  logic    accept;

  assign byte_stall = rec_valid && rec_stall;
  assign accept     = byte_valid && !byte_stall;

  always_comb begin
    cur.st  = st;
    cur.acc = '0;
    stepped = feed(cur, byte_data.in_byte);
    st_next = stepped.st;
    // The end-of-text stage finishes the text; the parser starts over.
    if (byte_data.in_last) begin
      st_next.phase     = PH_SEEK;
      st_next.hex_count = 2'd0;
      st_next.hex_value = 16'h0000;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase     <= PH_SEEK;
      st.hex_count <= 2'd0;
      st.hex_value <= 16'h0000;
      rec_valid    <= 1'b0;
    end else begin
      if (accept) st <= st_next;
      if (!byte_stall) rec_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rec.step <= stepped;
      rec.last <= byte_data.in_last;
    end
  end

endmodule

### src/jsat_close.sv
// Front end, second stage: closes the text on its last byte (held \u bytes,
// open escape, open string, open list) and drops bytes that give no token.
// Depends on jsat_pkg.
module jsat_close import jsat_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   rec_valid,
  output logic   rec_stall,
  input  rec_t   rec,
  output logic   burst_valid,
  input  logic   burst_stall,
  output burst_t burst
);

  step_t fin;

  assign rec_stall = burst_valid && burst_stall;

  always_comb begin
    fin = rec.last ? finish(rec.step) : rec.step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      burst_valid <= 1'b0;
    end else if (!rec_stall) begin
      burst_valid <= rec_valid && (fin.acc.cnt != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rec_stall) burst <= fin.acc;
  end

endmodule

### src/jsat_fifo.sv
// Short queue of token bursts between the front end and the serializer.
// Depends on jsat_pkg for the burst type and depth.
module jsat_fifo import jsat_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   wr_valid,
  output logic   wr_stall,
  input  burst_t wr_data,
  output logic   rd_valid,
  input  logic   rd_pop,
  output burst_t rd_data
);

  burst_t             mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;
  logic               wr;
  logic               rd;

  assign wr_stall = (count == (FIFO_AW + 1)'(FIFO_DEPTH));
  assign rd_valid = (count != '0);
  assign wr       = wr_valid && !wr_stall;
  assign rd       = rd_pop && rd_valid;
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) wr_ptr <= wr_ptr + FIFO_AW'(1);
      if (rd) rd_ptr <= rd_ptr + FIFO_AW'(1);
      unique case ({wr, rd})
        2'b10:   count <= count + (FIFO_AW + 1)'(1);
        2'b01:   count <= count - (FIFO_AW + 1)'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wr_ptr] <= wr_data;
  end

endmodule

### src/jsat_emit.sv
// Back end: walks the burst at the head of the queue and presents one token per
// cycle, while the output is not stalled, in the output register, marking the last
// token of each burst. Depends on jsat_pkg.
module jsat_emit import jsat_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      head_valid,
  input  burst_t    head,
  output logic      head_pop,
  output logic      tok_valid,
  input  logic      tok_stall,
  output out_item_t tok_data
);

  logic [TOK_IDX_W-1:0] idx;
  logic                 free;
  logic                 load;
  logic                 is_end;

  assign free     = !tok_valid || !tok_stall;
  assign load     = head_valid && free;
  assign is_end   = ({1'b0, idx} == head.cnt - TOK_CNT_W'(1));
  assign head_pop = load && is_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (free) tok_valid <= head_valid;
      if (load) idx <= is_end ? '0 : idx + TOK_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tok_data.out_kind <= head.tok[idx].kind;
      tok_data.out_byte <= head.tok[idx].data;
      tok_data.out_last <= is_end;
    end
  end

endmodule

### src/json_string_array_tokenizer.sv
// Streams a JSON text one byte per cycle while not stalled and returns the decoded
// bytes of each string of its top-level array as tokens, each string closed by an
// end-of-string token and the list by a list-finished token; the final token caused
// by one input byte carries out_last. Plain text, with at most one token per byte,
// runs at one byte per clock when nothing is stalled. A \u escape gives up to three
// tokens, the last byte of a text up to eight; the serializer in the back end emits
// one token per cycle while not stalled, and a four-entry burst queue between the
// parser and the serializer lets the input keep flowing across such bursts. Bytes
// that give no token never enter the queue. A token passes through the parser's record
// register, the closing stage's burst register, the queue and the output register.
// Depends on jsat_pkg, jsat_parse, jsat_close, jsat_fifo and jsat_emit.
module json_string_array_tokenizer import jsat_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      byte_valid,
  output logic      byte_stall,
  input  in_item_t  byte_data,
  output logic      tok_valid,
  input  logic      tok_stall,
  output out_item_t tok_data
);

  logic   rec_valid;
  logic   rec_stall;
  rec_t   rec;
  logic   burst_valid;
  logic   burst_stall;
  burst_t burst;
  logic   head_valid;
  logic   head_pop;
  burst_t head;

  jsat_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_data  (byte_data),
    .rec_valid  (rec_valid),
    .rec_stall  (rec_stall),
    .rec        (rec)
  );

  jsat_close u_close (
    .clk         (clk),
    .rst         (rst),
    .rec_valid   (rec_valid),
    .rec_stall   (rec_stall),
    .rec         (rec),
    .burst_valid (burst_valid),
    .burst_stall (burst_stall),
    .burst       (burst)
  );

  jsat_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (burst_valid),
    .wr_stall (burst_stall),
    .wr_data  (burst),
    .rd_valid (head_valid),
    .rd_pop   (head_pop),
    .rd_data  (head)
  );

  jsat_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop),
    .tok_valid  (tok_valid),
    .tok_stall  (tok_stall),
    .tok_data   (tok_data)
  );

  // The list-finished token always ends the tokens of its byte.
  a_eol_is_last: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok_data.out_kind == KIND_EOL |-> tok_data.out_last)
    else $error("list-finished token not marked last");

  // Markers carry no byte.
  a_marker_zero: assert property (@(posedge clk) disable iff (rst)
    tok_valid && (tok_data.out_kind == KIND_EOS || tok_data.out_kind == KIND_EOL)
    |-> tok_data.out_byte == 8'h00)
    else $error("marker token carries a nonzero byte");

  // The input is held off only while the parser's output register waits.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> rec_valid && rec_stall)
    else $error("input stalled with the parser stage free");

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for json_string_array_tokenizer: drives JSON texts byte by
// byte and checks every token against an in-bench model of the parser or, for some
// directed bytes, a typed token. Depends on jsat_pkg and the RTL under src.
module tb_top import jsat_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int TEXT_BYTES = 120;
  localparam string ESC_CHARS = "nrt\"\\/";
  localparam string HEX_CHARS = "0123456789abcdefABCDEF";

  typedef struct {
    logic [7:0] code;
    logic       last;
    int         n_typed;     // -1: use the model, else 0 or 1 typed token
    out_item_t  typed_tok;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      byte_valid = 1'b0;
  logic      byte_stall;
  in_item_t  byte_data = '0;
  logic      tok_valid;
  logic      tok_stall = 1'b0;
  out_item_t tok_data;

  int          send_idle_pct = 7;
  int          recv_stall_pct = 67;
  int          mismatches = 0;
  int unsigned cycle_cnt = 0;

  // Parser state of the model.
  phase_t     ph = PH_SEEK;
  logic [1:0] hcnt = 2'd0;
  logic [15:0] hval = 16'h0000;
  logic [7:0] held [3];

  out_item_t  step_toks[$];
  out_item_t  pending_tokens[$];
  logic [7:0] txt[$];
  bit         txt_noise;

  stim_row_t dir_rows [28] = '{
    '{8'h00,     1'b0, 0, '0},
    '{8'h20,     1'b0, 0, '0},
    '{CH_LBRACK, 1'b0, 0, '0},
    '{CH_QUOTE,  1'b0, 0, '0},
    '{8'hFF,     1'b0, 1, {KIND_DATA, 8'hFF, 1'b1}},
    '{8'h00,     1'b0, 1, {KIND_DATA, 8'h00, 1'b1}},
    '{CH_BSLASH, 1'b0, 0, '0},
    '{CH_LC_N,   1'b0, 1, {KIND_DATA, CH_LF, 1'b1}},
    '{CH_BSLASH, 1'b0, -1, '0},
    '{CH_LC_R,   1'b0, -1, '0},
    '{CH_BSLASH, 1'b0, -1, '0},
    '{CH_LC_U,   1'b0, -1, '0},
    '{8'h46,     1'b0, -1, '0},
    '{8'h46,     1'b0, -1, '0},
    '{8'h46,     1'b0, -1, '0},
    '{8'h46,     1'b0, -1, '0},
    '{CH_QUOTE,  1'b0, 1, {KIND_EOS, 8'h00, 1'b1}},
    '{CH_RBRACK, 1'b0, 1, {KIND_EOL, 8'h00, 1'b1}},
    '{8'h80,     1'b1, 0, '0},
    '{8'h61,     1'b1, 0, '0},
    '{CH_LBRACK, 1'b0, -1, '0},
    '{CH_QUOTE,  1'b0, -1, '0},
    '{CH_BSLASH, 1'b0, -1, '0},
    '{CH_LC_U,   1'b0, -1, '0},
    '{8'h34,     1'b1, -1, '0},
    '{CH_LBRACK, 1'b0, -1, '0},
    '{CH_QUOTE,  1'b0, -1, '0},
    '{CH_BSLASH, 1'b1, -1, '0}
  };

  json_string_array_tokenizer dut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_data  (byte_data),
    .tok_valid  (tok_valid),
    .tok_stall  (tok_stall),
    .tok_data   (tok_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    tok_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && tok_valid && !tok_stall) begin
      if (pending_tokens.size() == 0) begin
        $display("%0t: unexpected token, expected none, got kind %0d byte %02h last %0d",
                 $time, tok_data.out_kind, tok_data.out_byte, tok_data.out_last);
        mismatches++;
      end else begin
        want = pending_tokens.pop_front();
        if (tok_data.out_kind !== want.out_kind) begin
          $display("%0t: out_kind expected %0d, got %0d", $time, want.out_kind,
                   tok_data.out_kind);
          mismatches++;
        end
        if (tok_data.out_byte !== want.out_byte) begin
          $display("%0t: out_byte expected %02h, got %02h", $time, want.out_byte,
                   tok_data.out_byte);
          mismatches++;
        end
        if (tok_data.out_last !== want.out_last) begin
          $display("%0t: out_last expected %0d, got %0d", $time, want.out_last,
                   tok_data.out_last);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- model

  function automatic int nibble_of(logic [7:0] b);
    if (b >= 8'h30 && b <= 8'h39) return int'(b) - 'h30;
    if (b >= 8'h61 && b <= 8'h66) return int'(b) - 'h57;
    if (b >= 8'h41 && b <= 8'h46) return int'(b) - 'h37;
    return -1;
  endfunction

  // Tokens beyond the per-byte maximum are dropped.
  task automatic add_token(logic [1:0] kind, logic [7:0] b);
    out_item_t t;
    t.out_kind = kind;
    t.out_byte = (kind == KIND_DATA) ? b : 8'h00;
    t.out_last = 1'b0;
    if (step_toks.size() < MAX_TOK) step_toks.insert(step_toks.size(), t);
  endtask

  task automatic add_codepoint(logic [15:0] cp);
    if (cp < 16'h0080) begin
      add_token(KIND_DATA, cp[7:0]);
    end else if (cp < 16'h0800) begin
      add_token(KIND_DATA, 8'hC0 | 8'(cp >> 6));
      add_token(KIND_DATA, 8'h80 | 8'(cp & 16'h003F));
    end else begin
      add_token(KIND_DATA, 8'hE0 | 8'(cp >> 12));
      add_token(KIND_DATA, 8'h80 | 8'((cp >> 6) & 16'h003F));
      add_token(KIND_DATA, 8'h80 | 8'(cp & 16'h003F));
    end
  endtask

  task automatic parse_byte(logic [7:0] b);
    int d;
    case (ph)
      PH_SEEK: begin
        if (b > 8'h20) ph = (b == CH_LBRACK) ? PH_LIST : PH_DONE;
      end
      PH_LIST: begin
        if (b == CH_RBRACK) begin
          add_token(KIND_EOL, 8'h00);
          ph = PH_DONE;
        end else if (b == CH_QUOTE) begin
          ph = PH_STR;
        end
      end
      PH_STR: begin
        if (b == CH_QUOTE) begin
          add_token(KIND_EOS, 8'h00);
          ph = PH_LIST;
        end else if (b == CH_BSLASH) begin
          ph = PH_ESC;
        end else begin
          add_token(KIND_DATA, b);
        end
      end
      PH_ESC: begin
        ph = PH_STR;
        if (b == CH_LC_N) add_token(KIND_DATA, CH_LF);
        else if (b == CH_LC_R) add_token(KIND_DATA, CH_CR);
        else if (b == CH_LC_T) add_token(KIND_DATA, CH_TAB);
        else if (b == CH_LC_U) begin
          ph = PH_HEXD;
          hcnt = 2'd0;
          hval = 16'h0000;
        end else add_token(KIND_DATA, b);
      end
      PH_HEXD, PH_HEXR: begin
        // Only the hex digits before the first other byte make up the value.
        if (ph == PH_HEXD) begin
          d = nibble_of(b);
          if (d >= 0) hval = {hval[11:0], 4'(d)};
          else ph = PH_HEXR;
        end
        if (hcnt < 2'd3) begin
          held[hcnt] = b;
          hcnt++;
        end else begin
          add_codepoint(hval);
          hcnt = 2'd0;
          hval = 16'h0000;
          ph = PH_STR;
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic close_text();
    logic [7:0] tmp [3];
    int n;
    // An unfinished \u gives its held bytes back as plain string text,
    // which may itself open another \u.
    while (ph == PH_HEXD || ph == PH_HEXR) begin
      n = hcnt;
      for (int i = 0; i < n; i++) tmp[i] = held[i];
      ph = PH_STR;
      hcnt = 2'd0;
      hval = 16'h0000;
      for (int i = 0; i < n; i++) parse_byte(tmp[i]);
    end
    if (ph == PH_ESC) begin
      add_token(KIND_DATA, CH_BSLASH);
      ph = PH_STR;
    end
    if (ph == PH_STR) begin
      add_token(KIND_EOS, 8'h00);
      ph = PH_LIST;
    end
    if (ph == PH_LIST) add_token(KIND_EOL, 8'h00);
    ph = PH_SEEK;
    hcnt = 2'd0;
    hval = 16'h0000;
  endtask

  task automatic tokenize_byte(in_item_t it);
    step_toks.delete();
    parse_byte(it.in_byte);
    if (it.in_last) close_text();
    if (step_toks.size() > 0) step_toks[step_toks.size()-1].out_last = 1'b1;
  endtask

  task automatic expect_step();
    foreach (step_toks[k]) pending_tokens.insert(pending_tokens.size(), step_toks[k]);
  endtask

  // ------------------------------------------------------------ stimulus

  task automatic put_byte(logic [7:0] b);
    txt.insert(txt.size(), b);
  endtask

  // Returns at the rising edge where the byte is taken.
  task automatic send_byte(in_item_t it);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      byte_valid <= 1'b0;
      @(negedge clk);
    end
    byte_valid <= 1'b1;
    byte_data  <= it;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
  endtask

  task automatic gen_text();
    int r, nstr, cut;
    logic [7:0] b;
    txt.delete();
    txt_noise = 1'b0;
    if ($urandom_range(0, 99) < 12) begin
      txt_noise = 1'b1;
      repeat ($urandom_range(1, 10)) put_byte(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 2)) put_byte(8'($urandom_range(0, 32)));
      put_byte(CH_LBRACK);
      nstr = $urandom_range(0, 3);
      for (int s = 0; s < nstr; s++) begin
        if (s > 0) put_byte(8'h2C);
        if ($urandom_range(0, 5) == 0) put_byte(8'($urandom_range(0, 255)));
        put_byte(CH_QUOTE);
        repeat ($urandom_range(0, 5)) begin
          case ($urandom_range(0, 9))
            5: begin
              put_byte(CH_BSLASH);
              put_byte(ESC_CHARS[$urandom_range(0, 5)]);
            end
            6: begin
              put_byte(CH_BSLASH);
              put_byte(8'($urandom_range(0, 255)));
            end
            7, 8: begin
              put_byte(CH_BSLASH);
              put_byte(CH_LC_U);
              repeat (4) begin
                if ($urandom_range(0, 99) < 85) put_byte(HEX_CHARS[$urandom_range(0, 21)]);
                else put_byte(8'($urandom_range(0, 255)));
              end
            end
            default: begin
              do b = 8'($urandom_range(0, 255));
              while (b == CH_QUOTE || b == CH_BSLASH);
              put_byte(b);
            end
          endcase
        end
        put_byte(CH_QUOTE);
      end
      r = $urandom_range(0, 99);
      if (r < 15) begin
        // Text cut off inside a \u escape, sometimes with a nested one held.
        put_byte(CH_QUOTE);
        put_byte(CH_BSLASH);
        put_byte(CH_LC_U);
        repeat ($urandom_range(0, 3)) begin
          case ($urandom_range(0, 3))
            0: put_byte(CH_BSLASH);
            1: put_byte(CH_LC_U);
            2: put_byte(HEX_CHARS[$urandom_range(0, 21)]);
            default: put_byte(8'($urandom_range(0, 255)));
          endcase
        end
      end else if (r < 30) begin
        cut = $urandom_range(1, txt.size());
        while (txt.size() > cut) void'(txt.pop_back());
      end else if (r < 90) begin
        put_byte(CH_RBRACK);
        if ($urandom_range(0, 3) == 0) put_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic run_texts(int target);
    int sent;
    in_item_t it;
    sent = 0;
    while (sent < target) begin
      gen_text();
      foreach (txt[i]) begin
        it = '{in_byte: txt[i], in_last: (i == txt.size() - 1)};
        send_byte(it);
        tokenize_byte(it);
        expect_step();
      end
      if (!txt_noise) sent += txt.size();
    end
  endtask

  initial begin
    in_item_t it;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      it = '{in_byte: dir_rows[i].code, in_last: dir_rows[i].last};
      send_byte(it);
      tokenize_byte(it);
      if (dir_rows[i].n_typed < 0) begin
        expect_step();
      end else if (dir_rows[i].n_typed == 1) begin
        pending_tokens.insert(pending_tokens.size(), dir_rows[i].typed_tok);
      end
    end
    run_texts(TEXT_BYTES);

    send_idle_pct  = 67;
    recv_stall_pct = 7;
    run_texts(TEXT_BYTES);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_texts(TEXT_BYTES);

    @(negedge clk);
    byte_valid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
